>>> hdl/escape_sequence_decoder_defines.svh
// Assertion macros shared by the escape sequence decoder RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define ESD_ASSERT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("escape_sequence_decoder assertion failed");
// Next-cycle implication, disabled while reset is held.
`define ESD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("escape_sequence_decoder assertion failed");
`else
`define ESD_ASSERT(label, clk, rst_n, cond, prop)
`define ESD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

>>> hdl/esd_pkg.sv
// Package for the escape sequence decoder: result types, character codes and
// small decode functions. No dependencies.
package esd_pkg;

    localparam int FifoDepth = 3;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChX         = 8'h78;
    localparam logic [7:0] ChZero      = 8'h30;
    localparam logic [7:0] ChSeven     = 8'h37;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       dropped_escape;
        logic       end_of_string;
        logic       last_of_run;
    } t_result;

    // Results caused by one accepted input word, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

    function automatic t_result make_result(input logic [7:0] b, input logic has,
                                            input logic drop);
        t_result r;
        r.out_byte       = b;
        r.has_byte       = has;
        r.dropped_escape = drop;
        r.end_of_string  = 1'b0;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // Returns {hit, mapped byte} for the single-character escapes.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h5C, 8'h22, 8'h27: r = {1'b1, c};
            default: r = {1'b0, 8'd0};
        endcase
        return r;
    endfunction

    // Returns {hit, value} for a hexadecimal digit in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(FifoDepth - 1)) ? '0 : PtrW'(p + 1'b1);
    endfunction

endpackage

>>> hdl/esd_in_if.sv
// Input channel of the escape sequence decoder: one source byte per word.
// Depends on nothing.
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

>>> hdl/esd_out_if.sv
// Output channel of the escape sequence decoder: one decoded result per word.
// Depends on nothing.
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       dropped_escape;
    logic       end_of_string;
    logic       last_of_run;

    modport source (output valid, output out_byte, output has_byte, output dropped_escape,
                    output end_of_string, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input has_byte, input dropped_escape,
                  input end_of_string, input last_of_run, output ready);
endinterface

>>> hdl/esd_step.sv
// Escape decode state and the per-byte decode logic producing up to two results.
// Depends on esd_pkg.
module esd_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output esd_pkg::t_step o_step
);
    import esd_pkg::*;

    localparam logic [1:0] ModeText   = 2'd0;
    localparam logic [1:0] ModeEscape = 2'd1;
    localparam logic [1:0] ModeHex    = 2'd2;
    localparam logic [1:0] ModeOctal  = 2'd3;

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_value, n_value;
    logic [1:0] r_digits, n_digits;

    logic [8:0] simple;
    logic [4:0] hex;
    logic       is_oct;
    logic [7:0] oct_value;
    logic       f_v, p_v, t_v;
    t_result    f, p, t, e0, e1, drop_res;
    logic [1:0] cnt;

    assign simple    = simple_escape(i_byte);
    assign hex       = hex_digit(i_byte);
    assign is_oct    = (i_byte >= ChZero) && (i_byte <= ChSeven);
    assign oct_value = {r_value[4:0], i_byte[2:0]};
    assign drop_res  = make_result(8'd0, 1'b0, 1'b1);

    always_comb begin
        n_mode   = r_mode;
        n_value  = r_value;
        n_digits = r_digits;
        f_v      = 1'b0;
        f        = drop_res;
        p_v      = 1'b0;
        p        = make_result(i_byte, 1'b1, 1'b0);
        unique case (r_mode)
            ModeText: begin
                if (i_byte == ChBackslash) begin
                    n_mode = ModeEscape;
                end else begin
                    p_v = 1'b1;
                end
            end
            ModeEscape: begin
                if (simple[8]) begin
                    f_v    = 1'b1;
                    f      = make_result(simple[7:0], 1'b1, 1'b0);
                    n_mode = ModeText;
                end else if (i_byte == ChX) begin
                    n_mode   = ModeHex;
                    n_value  = 8'd0;
                    n_digits = 2'd0;
                end else if (is_oct) begin
                    n_mode   = ModeOctal;
                    n_value  = {5'd0, i_byte[2:0]};
                    n_digits = 2'd1;
                end else begin
                    f_v    = 1'b1;
                    n_mode = ModeText;
                end
            end
            ModeHex: begin
                if (hex[4]) begin
                    if (r_digits != 2'd0) begin
                        f_v      = 1'b1;
                        f        = make_result({r_value[3:0], hex[3:0]}, 1'b1, 1'b0);
                        n_mode   = ModeText;
                        n_value  = 8'd0;
                        n_digits = 2'd0;
                    end else begin
                        n_value  = {4'd0, hex[3:0]};
                        n_digits = 2'd1;
                    end
                end else begin
                    // The pending number (or the bare \x) is flushed, then the
                    // byte is decoded as ordinary text.
                    f_v      = 1'b1;
                    f        = (r_digits == 2'd0) ? drop_res
                                                  : make_result(r_value, 1'b1, 1'b0);
                    n_value  = 8'd0;
                    n_digits = 2'd0;
                    if (i_byte == ChBackslash) begin
                        n_mode = ModeEscape;
                    end else begin
                        n_mode = ModeText;
                        p_v    = 1'b1;
                    end
                end
            end
            ModeOctal: begin
                if (is_oct && r_digits != 2'd3) begin
                    if (r_digits == 2'd2) begin
                        f_v      = 1'b1;
                        f        = make_result(oct_value, 1'b1, 1'b0);
                        n_mode   = ModeText;
                        n_value  = 8'd0;
                        n_digits = 2'd0;
                    end else begin
                        n_value  = oct_value;
                        n_digits = 2'(r_digits + 1'b1);
                    end
                end else begin
                    f_v      = 1'b1;
                    f        = make_result(r_value, 1'b1, 1'b0);
                    n_value  = 8'd0;
                    n_digits = 2'd0;
                    if (i_byte == ChBackslash) begin
                        n_mode = ModeEscape;
                    end else begin
                        n_mode = ModeText;
                        p_v    = 1'b1;
                    end
                end
            end
            default: n_mode = ModeText;
        endcase

        // At string end, whatever escape is still open is closed out.
        t_v = 1'b1;
        t   = drop_res;
        case (n_mode)
            ModeHex: begin
                if (n_digits != 2'd0) begin
                    t = make_result(n_value, 1'b1, 1'b0);
                end
            end
            ModeOctal: t = make_result(n_value, 1'b1, 1'b0);
            ModeEscape: t = drop_res;
            default: t_v = 1'b0;
        endcase

        if (i_last) begin
            n_mode   = ModeText;
            n_value  = 8'd0;
            n_digits = 2'd0;
        end
    end

    // Pack the candidates into delivery order; a discard right after another
    // discard is merged into it.
    always_comb begin
        cnt = 2'd0;
        e0  = make_result(8'd0, 1'b0, 1'b0);
        e1  = make_result(8'd0, 1'b0, 1'b0);
        if (f_v) begin
            e0  = f;
            cnt = 2'd1;
        end
        if (p_v) begin
            if (cnt == 2'd0) begin
                e0  = p;
                cnt = 2'd1;
            end else begin
                e1  = p;
                cnt = 2'd2;
            end
        end
        if (i_last && t_v) begin
            if (cnt == 2'd0) begin
                e0  = t;
                cnt = 2'd1;
            end else if (cnt == 2'd1) begin
                if (!(!t.has_byte && t.dropped_escape && !e0.has_byte && e0.dropped_escape))
                begin
                    e1  = t;
                    cnt = 2'd2;
                end
            end
        end
        if (i_last && cnt == 2'd0) begin
            cnt = 2'd1;
        end
        if (cnt == 2'd1) begin
            e0.end_of_string = i_last;
            e0.last_of_run   = 1'b1;
        end else if (cnt == 2'd2) begin
            e1.end_of_string = i_last;
            e1.last_of_run   = 1'b1;
        end
    end

    assign o_step.count  = i_accept ? cnt : 2'd0;
    assign o_step.first  = e0;
    assign o_step.second = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ModeText;
            r_value  <= 8'd0;
            r_digits <= 2'd0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_value  <= n_value;
            r_digits <= n_digits;
        end
    end

endmodule

>>> hdl/esd_result_fifo.sv
// Three-entry result queue that takes up to two results per cycle and
// delivers one. Depends on esd_pkg and the assertion macro header.
`include "escape_sequence_decoder_defines.svh"
module esd_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  esd_pkg::t_step   i_step,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output esd_pkg::t_result o_result
);
    import esd_pkg::*;

    t_result          r_mem [FifoDepth];
    logic [PtrW-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CntW-1:0]  r_count, n_count, push_n;

    assign push_n   = CntW'(i_step.count);
    assign o_room   = (r_count <= CntW'(FifoDepth - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        if (push_n == CntW'(2)) begin
            n_wr = ptr_inc(ptr_inc(r_wr));
        end else if (push_n == CntW'(1)) begin
            n_wr = ptr_inc(r_wr);
        end
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = CntW'(r_count + push_n - CntW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_mem[r_wr] <= i_step.first;
        end
        if (push_n == CntW'(2)) begin
            r_mem[ptr_inc(r_wr)] <= i_step.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `ESD_ASSERT(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= CntW'(FifoDepth))
    `ESD_ASSERT(a_push_has_room, i_clk, i_rst_n, push_n != '0, r_count <= CntW'(FifoDepth - 2))
    `ESD_ASSERT_NEXT(a_drain_one, i_clk, i_rst_n, i_pop && push_n == '0, r_count == CntW'($past(r_count) - 1'b1))

endmodule

>>> hdl/escape_sequence_decoder.sv
// Escape sequence decoder, top level: C string escapes to decoded bytes.
// Channels: i_in carries one source byte and its string_end flag per word;
// o_out carries one decoded result per word (out_byte, has_byte,
// dropped_escape, end_of_string, last_of_run). Both use valid/ready.
// Each input byte yields zero, one or two results; last_of_run marks the
// final result of a byte and end_of_string the final result of a string.
// A result caused by an accepted byte is registered in the result queue and
// offered on o_out from the next cycle on.
// Throughput: one byte per cycle while i_in.ready is high. Bytes are decoded
// combinationally into a three-entry result queue; i_in.ready is high while at
// most one result is queued, so a byte that yields two results holds i_in off
// even with o_out draining every cycle.
// When o_out stalls, the queue fills and i_in.ready drops; nothing is lost.
// Reset (i_rst_n low at a clock edge) returns the decoder to plain text mode
// and empties the queue.
// Depends on esd_pkg, esd_in_if, esd_out_if, esd_step and esd_result_fifo.
module escape_sequence_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);
    import esd_pkg::*;

    logic    accept, room, pop;
    t_step   step;
    t_result head;

    assign accept = i_in.valid && room;
    assign pop    = o_out.valid && o_out.ready;
    assign i_in.ready = room;

    esd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.string_end),
        .o_step   (step)
    );

    esd_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_pop    (pop),
        .o_room   (room),
        .o_valid  (o_out.valid),
        .o_result (head)
    );

    assign o_out.out_byte       = head.out_byte;
    assign o_out.has_byte       = head.has_byte;
    assign o_out.dropped_escape = head.dropped_escape;
    assign o_out.end_of_string  = head.end_of_string;
    assign o_out.last_of_run    = head.last_of_run;

endmodule

>>> verif/escape_sequence_decoder_test.sv
// Self-checking testbench for the escape sequence decoder: a directed table of
// escapes, then random escaped strings checked against a cycle-free decoder model.
// Depends on esd_pkg, esd_in_if, esd_out_if and the escape_sequence_decoder RTL.
module escape_sequence_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import esd_pkg::*;

    localparam int DirectedRows  = 25;
    localparam int RandomWords   = 1550;
    localparam int CycleLimit    = 250000;
    localparam int HoldOffCycles = 120;
    localparam int HoldOffAfter  = 400;
    localparam int QuietTail     = 150;
    localparam int DrainCycles   = 8;
    localparam int MaxPrinted    = 40;
    localparam int Predicted     = -1;

    typedef enum logic [1:0] {ST_TEXT, ST_ESCAPE, ST_HEX, ST_OCTAL} t_decode_state;

    // One source word, with the results typed in when the row is hand-checked.
    typedef struct packed {
        logic [7:0] src_byte;
        logic       str_end;
        logic       typed;
        logic [1:0] n_typed;
        t_result    first;
        t_result    second;
    } t_source_word;

    localparam t_result NoRes = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    esd_in_if  in_ch();
    esd_out_if out_ch();

    escape_sequence_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    t_source_word  directed_table [DirectedRows];
    t_source_word  source_q[$];
    t_result       expected_q[$];

    // Decoder model state and the results of the word being decoded.
    t_decode_state esc_state;
    logic [8:0]    pending_value;
    logic [1:0]    digits_taken;
    t_result       decoded [2];
    int            n_decoded;

    int words_in;
    int results_out;
    int drops_seen;
    int ends_seen;
    int errors;
    bit hold_done;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MaxPrinted) begin
            $display("MISMATCH result %0d: %s", results_out, msg);
        end
    endtask

    function automatic void emit(input logic [7:0] b, input logic has, input logic drop);
        // A discard right after another discard of the same word folds into it.
        if (!has && drop && n_decoded > 0) begin
            if (!decoded[n_decoded-1].has_byte && decoded[n_decoded-1].dropped_escape) begin
                return;
            end
        end
        if (n_decoded < 2) begin
            decoded[n_decoded] = {b, has, drop, 2'b00};
            n_decoded++;
        end
    endfunction

    function automatic void take_text(input logic [7:0] c);
        if (c == ChBackslash) begin
            esc_state = ST_ESCAPE;
        end else begin
            esc_state = ST_TEXT;
            emit(c, 1'b1, 1'b0);
        end
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic void decode_word(input logic [7:0] c, input logic last);
        logic [4:0] nib;
        t_result    tail;
        n_decoded = 0;
        case (esc_state)
            ST_TEXT: take_text(c);
            ST_ESCAPE: begin
                esc_state = ST_TEXT;
                case (c)
                    "a": emit(8'd7, 1'b1, 1'b0);
                    "b": emit(8'd8, 1'b1, 1'b0);
                    "f": emit(8'd12, 1'b1, 1'b0);
                    "n": emit(8'd10, 1'b1, 1'b0);
                    "r": emit(8'd13, 1'b1, 1'b0);
                    "t": emit(8'd9, 1'b1, 1'b0);
                    "v": emit(8'd11, 1'b1, 1'b0);
                    ChBackslash, "\"", "'": emit(c, 1'b1, 1'b0);
                    ChX: begin
                        esc_state     = ST_HEX;
                        pending_value = '0;
                        digits_taken  = '0;
                    end
                    default: begin
                        if (c >= ChZero && c <= ChSeven) begin
                            esc_state     = ST_OCTAL;
                            pending_value = {6'd0, c[2:0]};
                            digits_taken  = 2'd1;
                        end else begin
                            emit(8'h00, 1'b0, 1'b1);
                        end
                    end
                endcase
            end
            ST_HEX: begin
                nib = hex_nibble(c);
                if (nib[4]) begin
                    pending_value = {pending_value[4:0], nib[3:0]};
                    digits_taken  = digits_taken + 2'd1;
                    if (digits_taken >= 2'd2) begin
                        emit(pending_value[7:0], 1'b1, 1'b0);
                        esc_state     = ST_TEXT;
                        pending_value = '0;
                        digits_taken  = '0;
                    end
                end else begin
                    // The byte that ends the number is decoded as text afterwards.
                    if (digits_taken == 2'd0) begin
                        emit(8'h00, 1'b0, 1'b1);
                    end else begin
                        emit(pending_value[7:0], 1'b1, 1'b0);
                    end
                    pending_value = '0;
                    digits_taken  = '0;
                    take_text(c);
                end
            end
            default: begin
                if (c >= ChZero && c <= ChSeven && digits_taken < 2'd3) begin
                    pending_value = {pending_value[5:0], c[2:0]};
                    digits_taken  = digits_taken + 2'd1;
                    if (digits_taken == 2'd3 || digits_taken == 2'd0) begin
                        emit(pending_value[7:0], 1'b1, 1'b0);
                        esc_state     = ST_TEXT;
                        pending_value = '0;
                        digits_taken  = '0;
                    end
                end else begin
                    emit(pending_value[7:0], 1'b1, 1'b0);
                    pending_value = '0;
                    digits_taken  = '0;
                    take_text(c);
                end
            end
        endcase
        if (last) begin
            case (esc_state)
                ST_ESCAPE: emit(8'h00, 1'b0, 1'b1);
                ST_HEX: begin
                    if (digits_taken != 2'd0) begin
                        emit(pending_value[7:0], 1'b1, 1'b0);
                    end else begin
                        emit(8'h00, 1'b0, 1'b1);
                    end
                end
                ST_OCTAL: emit(pending_value[7:0], 1'b1, 1'b0);
                default: ;
            endcase
            esc_state     = ST_TEXT;
            pending_value = '0;
            digits_taken  = '0;
            if (n_decoded == 0) begin
                decoded[0] = '0;
                n_decoded  = 1;
            end
            tail = decoded[n_decoded-1];
            tail.end_of_string = 1'b1;
            decoded[n_decoded-1] = tail;
        end
        if (n_decoded > 0) begin
            tail = decoded[n_decoded-1];
            tail.last_of_run = 1'b1;
            decoded[n_decoded-1] = tail;
        end
    endfunction

    function automatic t_source_word table_row(input logic [7:0] b, input logic e, input int n,
                                               input t_result r0, input t_result r1);
        t_source_word w;
        w.src_byte = b;
        w.str_end  = e;
        w.typed    = (n != Predicted);
        w.n_typed  = (n == Predicted) ? 2'd0 : 2'(n);
        w.first    = r0;
        w.second   = r1;
        return w;
    endfunction

    function automatic void push_source_byte(input logic [7:0] b);
        t_source_word w;
        w = '0;
        w.src_byte = b;
        w.str_end  = ($urandom_range(0, 19) == 0);
        source_q = {source_q, w};
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Predicts on every accepted source word and checks every accepted result.
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && in_ch.valid && in_ch.ready) begin
            decode_word(in_ch.in_byte, in_ch.string_end);
            if (source_q[words_in].typed) begin
                if (source_q[words_in].n_typed > 0) begin
                    expected_q = {expected_q, source_q[words_in].first};
                end
                if (source_q[words_in].n_typed > 1) begin
                    expected_q = {expected_q, source_q[words_in].second};
                end
            end else begin
                for (int i = 0; i < n_decoded; i++) begin
                    expected_q = {expected_q, decoded[i]};
                end
            end
            words_in++;
        end
        if (i_rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
            got = {out_ch.out_byte, out_ch.has_byte, out_ch.dropped_escape,
                   out_ch.end_of_string, out_ch.last_of_run};
            if (got.dropped_escape) begin
                drops_seen++;
            end
            if (got.end_of_string) begin
                ends_seen++;
            end
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word, byte %h", got.out_byte));
            end else begin
                want = expected_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              got.out_byte, want.out_byte));
                end
                if (got.has_byte !== want.has_byte) begin
                    report_mismatch($sformatf("has_byte %b, expected %b",
                                              got.has_byte, want.has_byte));
                end
                if (got.dropped_escape !== want.dropped_escape) begin
                    report_mismatch($sformatf("dropped_escape %b, expected %b",
                                              got.dropped_escape, want.dropped_escape));
                end
                if (got.end_of_string !== want.end_of_string) begin
                    report_mismatch($sformatf("end_of_string %b, expected %b",
                                              got.end_of_string, want.end_of_string));
                end
                if (got.last_of_run !== want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              got.last_of_run, want.last_of_run));
                end
            end
            results_out++;
        end
    end

    initial begin : source_driver
        int k;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= '0;
        in_ch.string_end <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        k = 0;
        while (k < source_q.size()) begin
            if (k < source_q.size() - QuietTail && $urandom_range(0, 7) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            in_ch.valid      <= 1'b1;
            in_ch.in_byte    <= source_q[k].src_byte;
            in_ch.string_end <= source_q[k].str_end;
            do @(posedge i_clk); while (!in_ch.ready);
            k++;
        end
        in_ch.valid <= 1'b0;
    end

    initial begin : result_sink
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (!hold_done && words_in >= HoldOffAfter) begin
                // One long stall so the result queue fills and the input backs up.
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
            end else if (words_in < source_q.size() - QuietTail &&
                         $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CycleLimit; cycles++) begin
            @(posedge i_clk);
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : main
        int    kind;
        int    n;
        string simple_set;
        string hex_set;
        simple_set    = "abfnrtv\\\"'";
        hex_set       = "0123456789abcdefABCDEF";
        esc_state     = ST_TEXT;
        pending_value = '0;
        digits_taken  = '0;

        directed_table[0]  = table_row(8'h41, 1'b0, 1, {8'h41, 4'b1001}, NoRes);
        directed_table[1]  = table_row(8'h00, 1'b0, 1, {8'h00, 4'b1001}, NoRes);
        directed_table[2]  = table_row(8'hFF, 1'b1, 1, {8'hFF, 4'b1011}, NoRes);
        directed_table[3]  = table_row(ChBackslash, 1'b0, 0, NoRes, NoRes);
        directed_table[4]  = table_row("u", 1'b0, 1, {8'h00, 4'b0101}, NoRes);
        directed_table[5]  = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[6]  = table_row("n", 1'b0, 1, {8'h0A, 4'b1001}, NoRes);
        // Hex escape with no digit: a discard, then the byte as text.
        directed_table[7]  = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[8]  = table_row(ChX, 1'b0, Predicted, NoRes, NoRes);
        directed_table[9]  = table_row("g", 1'b0, 2, {8'h00, 4'b0100}, {8'h67, 4'b1001});
        directed_table[10] = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[11] = table_row(ChX, 1'b0, Predicted, NoRes, NoRes);
        directed_table[12] = table_row("F", 1'b0, Predicted, NoRes, NoRes);
        directed_table[13] = table_row("f", 1'b0, 1, {8'hFF, 4'b1001}, NoRes);
        // Largest octal escape keeps only its low eight bits.
        directed_table[14] = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[15] = table_row(ChSeven, 1'b0, Predicted, NoRes, NoRes);
        directed_table[16] = table_row(ChSeven, 1'b0, Predicted, NoRes, NoRes);
        directed_table[17] = table_row(ChSeven, 1'b0, 1, {8'hFF, 4'b1001}, NoRes);
        directed_table[18] = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[19] = table_row("1", 1'b1, 1, {8'h01, 4'b1011}, NoRes);
        directed_table[20] = table_row(ChBackslash, 1'b1, 1, {8'h00, 4'b0111}, NoRes);
        directed_table[21] = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[22] = table_row("9", 1'b0, 1, {8'h00, 4'b0101}, NoRes);
        directed_table[23] = table_row(ChBackslash, 1'b0, Predicted, NoRes, NoRes);
        directed_table[24] = table_row(ChX, 1'b1, 1, {8'h00, 4'b0111}, NoRes);
        foreach (directed_table[i]) begin
            source_q = {source_q, directed_table[i]};
        end

        // Mostly well-formed escapes with random content, plus raw noise bytes.
        while (source_q.size() < DirectedRows + RandomWords) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                push_source_byte(8'($urandom_range(0, 255)));
            end else if (kind < 50) begin
                push_source_byte(ChBackslash);
                push_source_byte(simple_set[$urandom_range(0, 9)]);
            end else if (kind < 65) begin
                push_source_byte(ChBackslash);
                push_source_byte(ChX);
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++) begin
                    push_source_byte(hex_set[$urandom_range(0, 21)]);
                end
            end else if (kind < 80) begin
                push_source_byte(ChBackslash);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    push_source_byte(ChZero + 8'($urandom_range(0, 7)));
                end
            end else if (kind < 90) begin
                push_source_byte(ChBackslash);
                push_source_byte(8'($urandom_range(0, 255)));
            end else begin
                push_source_byte(8'($urandom_range(0, 255)));
            end
        end

        while (words_in < source_q.size()) begin
            @(posedge i_clk);
        end
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("Ran %0d source words (%0d from the directed table) through the decoder.",
                 words_in, DirectedRows);
        $display("Checked %0d results: %0d string ends, %0d discarded escapes, %0d errors.",
                 results_out, ends_seen, drops_seen, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
